>>> src/mlk_pkg.sv
// Shared types, constants and the character code ROM for the Morse LED keyer.
// No dependencies; imported by mlk_core and morse_led_keyer_unit.
package mlk_pkg;

  localparam int unsigned TickCntBits = 16;
  localparam int unsigned DotTicksW   = 16;
  localparam int unsigned StrengthW   = 8;
  // Compare width: wide enough for either operand plus one carry bit.
  localparam int unsigned CmpW = ((TickCntBits > DotTicksW) ? TickCntBits : DotTicksW) + 1;

  localparam logic [DotTicksW-1:0] DotTicksRst = DotTicksW'(150);
  localparam logic [StrengthW-1:0] StrengthRst = StrengthW'(255);

  localparam logic [3:0] UnitsDot      = 4'd1;
  localparam logic [3:0] UnitsDash     = 4'd3;
  localparam logic [3:0] UnitsCharGap  = 4'd3;
  localparam logic [3:0] UnitsEndGap   = 4'd7;
  localparam logic [3:0] UnitsSpaceGap = 4'd14;

  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [0:0] {
    CfgDotTicks = 1'b0,
    CfgStrength = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeTick = 2'd0,
    ModeChar = 2'd1,
    ModeEnd  = 2'd2,
    ModeNop  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhPre  = 3'd1,
    PhOn   = 3'd2,
    PhEgap = 3'd3,
    PhEnd  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic [7:0] led_level;
    logic       accepted;
    logic       busy_res;
    logic       done_res;
  } out_t;

  // Element pattern: bit 0 keyed first, 1 = dash.
  typedef struct packed {
    logic [4:0] bits;
    logic [2:0] count;
  } code_t;

  function automatic code_t code_lookup(input logic [7:0] c);
    code_t      r;
    logic [7:0] lc;
    lc = c | 8'h20;
    r  = '{bits: 5'b00000, count: 3'd0};
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      case (lc)
        8'h61: r = '{5'b00010, 3'd2};  // a
        8'h62: r = '{5'b00001, 3'd4};
        8'h63: r = '{5'b00101, 3'd4};
        8'h64: r = '{5'b00001, 3'd3};
        8'h65: r = '{5'b00000, 3'd1};
        8'h66: r = '{5'b00100, 3'd4};
        8'h67: r = '{5'b00011, 3'd3};
        8'h68: r = '{5'b00000, 3'd4};
        8'h69: r = '{5'b00000, 3'd2};
        8'h6A: r = '{5'b01110, 3'd4};
        8'h6B: r = '{5'b00101, 3'd3};
        8'h6C: r = '{5'b00010, 3'd4};
        8'h6D: r = '{5'b00011, 3'd2};
        8'h6E: r = '{5'b00001, 3'd2};
        8'h6F: r = '{5'b00111, 3'd3};
        8'h70: r = '{5'b00110, 3'd4};
        8'h71: r = '{5'b01011, 3'd4};
        8'h72: r = '{5'b00010, 3'd3};
        8'h73: r = '{5'b00000, 3'd3};
        8'h74: r = '{5'b00001, 3'd1};
        8'h75: r = '{5'b00100, 3'd3};
        8'h76: r = '{5'b01000, 3'd4};
        8'h77: r = '{5'b00110, 3'd3};
        8'h78: r = '{5'b01001, 3'd4};
        8'h79: r = '{5'b01101, 3'd4};
        8'h7A: r = '{5'b00011, 3'd4};  // z
        default: r = '{5'b00000, 3'd0};
      endcase
    end else begin
      case (c)
        8'h30: r = '{5'b11111, 3'd5};  // 0
        8'h31: r = '{5'b11110, 3'd5};
        8'h32: r = '{5'b11100, 3'd5};
        8'h33: r = '{5'b11000, 3'd5};
        8'h34: r = '{5'b10000, 3'd5};
        8'h35: r = '{5'b00000, 3'd5};
        8'h36: r = '{5'b00001, 3'd5};
        8'h37: r = '{5'b00011, 3'd5};
        8'h38: r = '{5'b00111, 3'd5};
        8'h39: r = '{5'b01111, 3'd5};  // 9
        default: r = '{5'b00000, 3'd0};
      endcase
    end
    return r;
  endfunction

endpackage

>>> src/morse_led_keyer_unit.sv
// Top level of the Morse LED keyer: config registers, input register, result register.
// Depends on mlk_pkg and mlk_core.

// Keys ASCII text as Morse code on an 8-bit LED level. Every input transfer is one
// item: mode 0 is one tick of time, mode 1 offers a character, mode 2 marks end of
// text; each item gives exactly one result transfer (led_level, accepted, busy_res,
// done_res). One time unit is dot_ticks ticks (0 acts as 1); a dot is 1 unit on, a
// dash 3, with 1 unit off between elements, 3 units before each character after the
// first, 14 units for a space and 7 units after end of text, which closes with a
// done pulse. Characters and end marks offered while busy come back with accepted
// low and change nothing. The item is held in the input register and its result then
// in the result register, whose output is the result channel; one item is taken per
// cycle, sustained, while the output is not stalled, since the keyer state update is
// a single pass of logic between the input register and the result register. The
// input stalls only when both registers hold an item and the output is stalled.
// Config writes (index 0 dot_ticks, index 1 strength) take effect at once and are
// meant for idle periods.
module morse_led_keyer_unit import mlk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_index_i,
  input  logic [DotTicksW-1:0] cfg_data_i
);

  logic [DotTicksW-1:0] dot_ticks_q;
  logic [StrengthW-1:0] strength_q;

  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;

  logic step;      // input register hands its item to the keyer
  logic out_free;  // result register can take a new result
  out_t res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q <= DotTicksRst;
      strength_q  <= StrengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDotTicks: dot_ticks_q <= cfg_data_i;
        CfgStrength: strength_q  <= cfg_data_i[StrengthW-1:0];
      endcase
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  // Input register empties whenever its item steps, so it refills in the same cycle.
  assign in_stall_o = in_vld_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  mlk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .dot_ticks_i (dot_ticks_q),
    .strength_i  (strength_q),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> src/mlk_core.sv
// Keyer state and per-item update: phase, element pattern, unit and tick counters.
// Depends on mlk_pkg (types, code ROM).
module mlk_core import mlk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,      // item in the input register moves on
  input  in_t                  item_i,
  input  logic [DotTicksW-1:0] dot_ticks_i,
  input  logic [StrengthW-1:0] strength_i,
  output out_t                 res_o
);

  phase_e                 phase_q, phase_d;
  logic [4:0]             sym_bits_q, sym_bits_d;
  logic [2:0]             sym_left_q, sym_left_d;
  logic [3:0]             units_q, units_d;
  logic [TickCntBits-1:0] tick_q, tick_d;
  logic                   first_q, first_d;

  logic            busy;
  logic            unit_end;
  logic            last_unit;
  logic [CmpW-1:0] tick_inc;
  code_t           code;
  logic [3:0]      char_gap;
  logic [4:0]      shifted;
  logic [2:0]      left_dec;
  mode_e           mode;

  assign mode      = mode_e'(item_i.mode);
  assign busy      = (phase_q != PhIdle);
  assign tick_inc  = CmpW'(tick_q) + CmpW'(1);
  assign unit_end  = (tick_inc >= CmpW'(dot_ticks_i)) || (&tick_q);
  assign last_unit = (units_q <= 4'd1);
  assign code      = code_lookup(item_i.char_code);
  assign shifted   = {1'b0, sym_bits_q[4:1]};
  assign left_dec  = sym_left_q - 3'd1;

  always_comb begin
    if (item_i.char_code == CharSpace) char_gap = UnitsSpaceGap;
    else if (first_q)                  char_gap = 4'd0;
    else                               char_gap = UnitsCharGap;
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    sym_bits_d = sym_bits_q;
    sym_left_d = sym_left_q;
    units_d    = units_q;
    tick_d     = tick_q;
    first_d    = first_q;
    unique case (mode)
      ModeTick: begin
        if (busy) begin
          if (!unit_end) begin
            tick_d = tick_inc[TickCntBits-1:0];
          end else begin
            tick_d = '0;
            if (!last_unit) begin
              units_d = units_q - 4'd1;
            end else begin
              units_d = 4'd0;
              case (phase_q)
                PhPre: begin
                  if (sym_left_q != 3'd0) begin
                    phase_d = PhOn;
                    units_d = sym_bits_q[0] ? UnitsDash : UnitsDot;
                  end else begin
                    phase_d = PhIdle;
                  end
                end
                PhOn: begin
                  sym_bits_d = shifted;
                  sym_left_d = left_dec;
                  if (left_dec != 3'd0) begin
                    phase_d = PhEgap;
                    units_d = UnitsDot;
                  end else begin
                    phase_d = PhIdle;
                  end
                end
                PhEgap: begin
                  phase_d = PhOn;
                  units_d = sym_bits_q[0] ? UnitsDash : UnitsDot;
                end
                default: phase_d = PhIdle;  // end gap finished
              endcase
            end
          end
        end
      end
      ModeChar: begin
        if (!busy) begin
          sym_bits_d = code.bits;
          sym_left_d = code.count;
          first_d    = 1'b0;
          tick_d     = '0;
          if (char_gap != 4'd0) begin
            phase_d = PhPre;
            units_d = char_gap;
          end else if (code.count != 3'd0) begin
            phase_d = PhOn;
            units_d = code.bits[0] ? UnitsDash : UnitsDot;
          end else begin
            phase_d = PhIdle;
            tick_d  = tick_q;
          end
        end
      end
      ModeEnd: begin
        if (!busy) begin
          sym_bits_d = '0;
          sym_left_d = '0;
          first_d    = 1'b1;
          phase_d    = PhEnd;
          units_d    = UnitsEndGap;
          tick_d     = '0;
        end
      end
      ModeNop: ;
    endcase
  end

  // Result for this item: LED level and busy from the updated state, the rest from the current state
  always_comb begin
    res_o.led_level = (phase_d == PhOn) ? strength_i : '0;
    res_o.accepted  = !busy && (mode == ModeChar || mode == ModeEnd);
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = (mode == ModeTick) && (phase_q == PhEnd) && unit_end && last_unit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      sym_bits_q <= '0;
      sym_left_q <= '0;
      units_q    <= '0;
      tick_q     <= '0;
      first_q    <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      sym_bits_q <= sym_bits_d;
      sym_left_q <= sym_left_d;
      units_q    <= units_d;
      tick_q     <= tick_d;
      first_q    <= first_d;
    end
  end

endmodule
